// ----- src/ipwd_pkg.sv -----
// shared types and constants for the ir pulse width frame decoder
package ipwd_pkg;

	localparam int DURATION_WIDTH = 16;
	localparam int S_TDATA_WIDTH = ((DURATION_WIDTH + 7) / 8) * 8;
	localparam int CFG_WIDTH = 16;
	localparam int CMP_WIDTH = (DURATION_WIDTH > CFG_WIDTH) ? DURATION_WIDTH : CFG_WIDTH;

	localparam int LEN_WIDTH = 8;
	localparam int BITS_WIDTH = 20;
	localparam int CMD_BITS = 7;
	localparam int ADDR_BITS = 5;
	localparam int EXT_BITS = 8;
	localparam int EXT_SHIFT = 8;

	localparam logic [LEN_WIDTH-1:0] SHORT_LEN = 8'd26;
	localparam logic [LEN_WIDTH-1:0] LONG_LEN = 8'd42;
	localparam logic [LEN_WIDTH-1:0] SHORT_END_POS = 8'd25;
	localparam logic [LEN_WIDTH-1:0] LONG_END_POS = 8'd41;
	localparam logic [LEN_WIDTH-1:0] LEN_MAX = 8'd255;

	localparam logic [CFG_WIDTH-1:0] ONE_BIT_MIN_RESET = 16'd1100;
	localparam logic [CFG_WIDTH-1:0] ONE_BIT_MAX_RESET = 16'd1300;

	// request kinds
	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	// configuration register indexes
	localparam logic REG_ONE_BIT_MIN = 1'b0;
	localparam logic REG_ONE_BIT_MAX = 1'b1;

	// frame kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_SHORT = 2'd1;
	localparam logic [1:0] KIND_LONG = 2'd2;

	typedef struct packed {
		logic [15:0] address_code;
		logic [7:0] command_code;
		logic [1:0] frame_kind;
		logic frame_ok;
	} result_t;

endpackage

// ----- src/ipwd_core.sv -----
// capture state, bit classification and frame decode for one request per cycle while fire is high
module ipwd_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [ipwd_pkg::CFG_WIDTH-1:0] cfg_data,
	input logic fire,
	input logic cmd,
	input logic [ipwd_pkg::DURATION_WIDTH-1:0] duration,
	output ipwd_pkg::result_t result
);

	logic [ipwd_pkg::CFG_WIDTH-1:0] one_bit_min_q;
	logic [ipwd_pkg::CFG_WIDTH-1:0] one_bit_max_q;
	logic [ipwd_pkg::LEN_WIDTH-1:0] capture_length_q;
	logic [ipwd_pkg::BITS_WIDTH-1:0] data_bits_q;
	logic end_of_short_is_zero_q;
	logic end_of_long_is_zero_q;

	logic is_one;
	logic dur_zero;
	logic short_ok;
	logic long_ok;
	logic [ipwd_pkg::BITS_WIDTH-1:0] data_bits_next;
	logic [ipwd_pkg::LEN_WIDTH-1:0] len_next;

	assign is_one = (ipwd_pkg::CMP_WIDTH'(duration) > ipwd_pkg::CMP_WIDTH'(one_bit_min_q)) &&
		(ipwd_pkg::CMP_WIDTH'(duration) < ipwd_pkg::CMP_WIDTH'(one_bit_max_q));
	assign dur_zero = (duration == '0);
	assign short_ok = (capture_length_q >= ipwd_pkg::SHORT_LEN) && end_of_short_is_zero_q;
	assign long_ok = (capture_length_q >= ipwd_pkg::LONG_LEN) && end_of_long_is_zero_q;

	// even positions 2..40 carry data bits lsb first
	always_comb begin
		data_bits_next = data_bits_q;
		for (int i = 0; i < ipwd_pkg::BITS_WIDTH; i++) begin
			if (capture_length_q == ipwd_pkg::LEN_WIDTH'(2 * i + 2)) begin
				data_bits_next[i] = is_one;
			end
		end
	end

	always_comb begin
		len_next = capture_length_q;
		result.frame_ok = 1'b0;
		result.frame_kind = ipwd_pkg::KIND_NONE;
		result.command_code = capture_length_q;
		result.address_code = 16'(capture_length_q);
		if (cmd == ipwd_pkg::CMD_APPEND) begin
			if (capture_length_q != ipwd_pkg::LEN_MAX) begin
				len_next = capture_length_q + 1'b1;
			end
		end else if (short_ok) begin
			len_next = '0;
			result.frame_ok = 1'b1;
			result.frame_kind = ipwd_pkg::KIND_SHORT;
			result.command_code = 8'(data_bits_q[ipwd_pkg::CMD_BITS-1:0]);
			result.address_code = 16'(data_bits_q[ipwd_pkg::CMD_BITS +: ipwd_pkg::ADDR_BITS]);
		end else if (long_ok) begin
			len_next = '0;
			result.frame_ok = 1'b1;
			result.frame_kind = ipwd_pkg::KIND_LONG;
			result.command_code = 8'(data_bits_q[ipwd_pkg::CMD_BITS-1:0]);
			result.address_code =
				(16'(data_bits_q[ipwd_pkg::CMD_BITS + ipwd_pkg::ADDR_BITS +: ipwd_pkg::EXT_BITS])
					<< ipwd_pkg::EXT_SHIFT) |
				16'(data_bits_q[ipwd_pkg::CMD_BITS +: ipwd_pkg::ADDR_BITS]);
		end else if (capture_length_q >= ipwd_pkg::LONG_LEN) begin
			len_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_bit_min_q <= ipwd_pkg::ONE_BIT_MIN_RESET;
			one_bit_max_q <= ipwd_pkg::ONE_BIT_MAX_RESET;
		end else if (cfg_we) begin
			if (cfg_index == ipwd_pkg::REG_ONE_BIT_MIN) begin
				one_bit_min_q <= cfg_data;
			end else begin
				one_bit_max_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_length_q <= '0;
			data_bits_q <= '0;
			end_of_short_is_zero_q <= 1'b0;
			end_of_long_is_zero_q <= 1'b0;
		end else if (fire) begin
			capture_length_q <= len_next;
			if (cmd == ipwd_pkg::CMD_APPEND) begin
				data_bits_q <= data_bits_next;
				if (capture_length_q == ipwd_pkg::SHORT_END_POS) begin
					end_of_short_is_zero_q <= dur_zero;
				end
				if (capture_length_q == ipwd_pkg::LONG_END_POS) begin
					end_of_long_is_zero_q <= dur_zero;
				end
			end
		end
	end

endmodule

// ----- src/ir_pulse_width_frame_decoder.sv -----
// top level of the ir pulse width frame decoder: input register, core and result register
//
// usage
//   slave stream: s_tuser selects the request, 0 appends the captured duration in
//   s_tdata to the capture sequence, 1 polls for a decoded frame
//   master stream: one result per poll, none per append; m_tuser carries frame_ok
//   and frame_kind (0 none, 1 twelve-bit, 2 twenty-bit), m_tdata carries the
//   command code and the address code (the capture length on a failed poll)
//   config port: cfg_we writes cfg_data into register cfg_index (0 one_bit_min,
//   1 one_bit_max); write only while the block is idle, which it does not enforce
// timing
//   a request waits in the input register; a poll is decoded from there into the
//   result register and its result is offered on the master side from then on;
//   the input register and the result register let a new request be taken every
//   cycle while no poll is held back by a waiting result
// reset
//   arst_n clears the capture length, data bits and end flags, sets the bounds to
//   1100 and 1300 ticks and empties both registers
// stalls
//   while m_tready is low and a result waits, appends keep flowing; a poll waits in
//   the input register with s_tready low until the result register frees
module ir_pulse_width_frame_decoder (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [ipwd_pkg::S_TDATA_WIDTH-1:0] s_tdata,   // [15:0] duration
	input logic [0:0] s_tuser,    // [0] cmd
	output logic m_tvalid,
	input logic m_tready,
	output logic [23:0] m_tdata,  // [7:0] command_code, [23:8] address_code
	output logic [2:0] m_tuser,   // [0] frame_ok, [2:1] frame_kind
	input logic cfg_we,
	input logic cfg_index,
	input logic [ipwd_pkg::CFG_WIDTH-1:0] cfg_data
);

	// input register
	logic valid_s1;
	logic cmd_s1;
	logic [ipwd_pkg::DURATION_WIDTH-1:0] duration_s1;

	// result register
	logic m_valid_q;
	ipwd_pkg::result_t result_q;

	ipwd_pkg::result_t result;
	logic fire;
	logic s_fire;

	// an append never needs the result register; a poll needs it free or draining
	assign fire = valid_s1 &&
		((cmd_s1 == ipwd_pkg::CMD_APPEND) || !m_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign s_fire = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_s1 <= s_tuser[0];
			duration_s1 <= ipwd_pkg::DURATION_WIDTH'(s_tdata);
		end
	end

	ipwd_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fire(fire),
		.cmd(cmd_s1),
		.duration(duration_s1),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire && (cmd_s1 == ipwd_pkg::CMD_POLL)) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (cmd_s1 == ipwd_pkg::CMD_POLL)) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {result_q.address_code, result_q.command_code};
	assign m_tuser = {result_q.frame_kind, result_q.frame_ok};

endmodule

// ----- bench/tb.sv -----
// self-checking bench for the ir pulse width frame decoder: directed table, then random frames
module tb;
	import ipwd_pkg::*;

	localparam int REQS_PER_PHASE = 150;  // random requests per bounds setting
	localparam int NUM_PHASES = 6;
	localparam int SETTLE_CYCLES = 4;     // two-stage pipe plus margin before a config write
	localparam int TIMEOUT = 2_000_000;   // watchdog limit in time units, far above a correct run

	// one line of the directed table: a request repeated reps times, with an optional
	// hand-typed result for a failed poll
	typedef struct packed {
		logic cmd;
		logic [15:0] dur;
		logic [9:0] reps;
		logic typed;
		result_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [15:0] s_tdata;          // [15:0] duration
	logic [0:0] s_tuser;           // [0] cmd
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;          // [7:0] command_code, [23:8] address_code
	logic [2:0] m_tuser;           // [0] frame_ok, [2:1] frame_kind
	logic cfg_we;
	logic cfg_index;
	logic [CFG_WIDTH-1:0] cfg_data;

	// capture state as the bench predicts it
	logic [LEN_WIDTH-1:0] cap_len;
	logic [BITS_WIDTH-1:0] frame_bits;
	logic short_end_zero;
	logic long_end_zero;
	logic [CFG_WIDTH-1:0] bound_lo;
	logic [CFG_WIDTH-1:0] bound_hi;

	result_t pending_frames[$];    // decoded frames still owed by the block, oldest first
	int errors = 0;
	int req_count = 0;
	int src_idle_pct = 37;
	int snk_idle_pct = 37;

	ir_pulse_width_frame_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// watchdog
	initial begin
		#TIMEOUT;
		$display("== FAIL ==");
		$finish;
	end

	// advance the capture state by one request; returns 1 with the decoded frame on a poll
	function automatic bit decode_request(input logic cmd, input logic [15:0] dur,
			output result_t res);
		int k;
		res = '0;
		if (cmd == CMD_APPEND) begin
			// even positions 2..40 carry data bits, lsb first
			if (cap_len >= 2 && cap_len <= 40 && !cap_len[0]) begin
				k = (cap_len - 2) / 2;
				frame_bits[k] = (dur > bound_lo) && (dur < bound_hi);
			end
			if (cap_len == SHORT_END_POS)
				short_end_zero = (dur == '0);
			if (cap_len == LONG_END_POS)
				long_end_zero = (dur == '0);
			// length sticks at its maximum
			if (cap_len != LEN_MAX)
				cap_len = cap_len + 1'b1;
			return 1'b0;
		end
		// twelve-bit frame takes precedence over twenty-bit
		if (cap_len >= SHORT_LEN && short_end_zero) begin
			res.frame_ok = 1'b1;
			res.frame_kind = KIND_SHORT;
			res.command_code = {1'b0, frame_bits[CMD_BITS-1:0]};
			res.address_code = {11'b0, frame_bits[CMD_BITS+ADDR_BITS-1:CMD_BITS]};
			cap_len = '0;
		end else if (cap_len >= LONG_LEN && long_end_zero) begin
			res.frame_ok = 1'b1;
			res.frame_kind = KIND_LONG;
			res.command_code = {1'b0, frame_bits[CMD_BITS-1:0]};
			res.address_code = {frame_bits[BITS_WIDTH-1:CMD_BITS+ADDR_BITS], 3'b0,
				frame_bits[CMD_BITS+ADDR_BITS-1:CMD_BITS]};
			cap_len = '0;
		end else begin
			// failed poll echoes the length, clears it only from 42 up
			res.frame_kind = KIND_NONE;
			res.command_code = cap_len;
			res.address_code = {8'b0, cap_len};
			if (cap_len >= LONG_LEN)
				cap_len = '0;
		end
		return 1'b1;
	endfunction

	// duration biased toward the bounds and the field extremes
	function automatic logic [15:0] pick_duration();
		logic [15:0] d;
		case ($urandom_range(9))
			0: d = bound_lo;
			1: d = bound_lo + 16'd1;
			2: d = bound_hi - 16'd1;
			3: d = bound_hi;
			4: d = '0;
			5: d = 16'hFFFF;
			6, 7: d = 16'($urandom_range(bound_hi, bound_lo));
			default: d = 16'($urandom);
		endcase
		return d;
	endfunction

	function automatic stim_row_t dir_row(input logic cmd, input logic [15:0] dur,
			input int reps, input bit typed = 1'b0, input int fail_len = 0);
		stim_row_t r;
		r.cmd = cmd;
		r.dur = dur;
		r.reps = 10'(reps);
		r.typed = typed;
		r.want = '0;
		r.want.frame_kind = KIND_NONE;
		r.want.command_code = 8'(fail_len);
		r.want.address_code = 16'(fail_len);
		return r;
	endfunction

	// present one request, with random idle cycles ahead of it, and wait for acceptance;
	// valid stays high on return so back-to-back requests need no extra assignment
	task automatic send_req(input logic cmd, input logic [15:0] dur, input bit typed,
			input result_t want);
		bit lowered;
		result_t res;
		lowered = 1'b0;
		while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			if (!lowered) begin
				s_tvalid <= 1'b0;
				lowered = 1'b1;
			end
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= dur;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		req_count++;
		if (decode_request(cmd, dur, res))
			pending_frames.push_back(typed ? want : res);
	endtask

	// well-formed frame with random content, now and then a broken end marker
	task automatic send_frame(input bit long_frame);
		int n;
		logic [15:0] d;
		// bring the capture length back to zero first
		if (cap_len != '0) begin
			while (cap_len < LONG_LEN)
				send_req(CMD_APPEND, 16'hFFFF, 1'b0, '0);
			d = 16'($urandom);
			send_req(CMD_POLL, d, 1'b0, '0);
		end
		n = long_frame ? LONG_LEN : SHORT_LEN;
		if ($urandom_range(3) == 0)
			n += $urandom_range(6);
		for (int p = 0; p < n; p++) begin
			d = pick_duration();
			if (p == SHORT_END_POS && $urandom_range(11) != 0)
				d = long_frame ? ((d == '0) ? 16'd1 : d) : 16'd0;
			if (p == LONG_END_POS && $urandom_range(11) != 0)
				d = '0;
			send_req(CMD_APPEND, d, 1'b0, '0);
		end
		d = 16'($urandom);
		send_req(CMD_POLL, d, 1'b0, '0);
	endtask

	// short burst of arbitrary appends and polls
	task automatic send_noise();
		int n;
		logic [15:0] d;
		n = $urandom_range(24, 1);
		repeat (n) begin
			d = ($urandom_range(3) == 0) ? pick_duration() : 16'($urandom);
			if ($urandom_range(5) == 0)
				send_req(CMD_POLL, d, 1'b0, '0);
			else
				send_req(CMD_APPEND, d, 1'b0, '0);
		end
	endtask

	// stop requesting, collect every owed frame and let the pipe empty
	task automatic drain_requests();
		s_tvalid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// both bound registers, one after the other, while the block is idle
	task automatic write_bounds(input logic [CFG_WIDTH-1:0] lo, input logic [CFG_WIDTH-1:0] hi);
		cfg_we <= 1'b1;
		cfg_index <= REG_ONE_BIT_MIN;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= REG_ONE_BIT_MAX;
		cfg_data <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		bound_lo = lo;
		bound_hi = hi;
	endtask

	// result side: random back-pressure, each frame checked against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_frames.size() == 0) begin
					$display("%0t: unexpected frame result, got user=%h data=%h",
						$time, m_tuser, m_tdata);
					errors++;
				end else begin
					want = pending_frames.pop_front();
					if (m_tuser[0] !== want.frame_ok || m_tuser[2:1] !== want.frame_kind ||
							m_tdata[7:0] !== want.command_code ||
							m_tdata[23:8] !== want.address_code) begin
						$display("%0t: frame mismatch, expected ok=%0d kind=%0d cmd=%0d addr=%0d",
							$time, want.frame_ok, want.frame_kind, want.command_code,
							want.address_code);
						$display("%0t:                 actual ok=%0d kind=%0d cmd=%0d addr=%0d",
							$time, m_tuser[0], m_tuser[2:1], m_tdata[7:0], m_tdata[23:8]);
						errors++;
					end
				end
			end
			m_tready <= (snk_idle_pct == 0) || ($urandom_range(99) >= snk_idle_pct);
		end
	end

	initial begin
		stim_row_t dir_rows[$];
		logic [CFG_WIDTH-1:0] lo;
		logic [CFG_WIDTH-1:0] hi;
		int phase_start;
		int choice;
		logic [15:0] d;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_APPEND;
		cfg_we = 1'b0;
		cfg_index = REG_ONE_BIT_MIN;
		cfg_data = '0;
		cap_len = '0;
		frame_bits = '0;
		short_end_zero = 1'b0;
		long_end_zero = 1'b0;
		bound_lo = ONE_BIT_MIN_RESET;
		bound_hi = ONE_BIT_MAX_RESET;

		// poll straight after reset finds an empty capture
		dir_rows.push_back(dir_row(CMD_POLL, 16'd0, 1, 1'b1, 0));
		// field extremes, then a failed poll below 42 keeps the length
		dir_rows.push_back(dir_row(CMD_APPEND, 16'hFFFF, 1));
		dir_rows.push_back(dir_row(CMD_APPEND, 16'd0, 1));
		dir_rows.push_back(dir_row(CMD_POLL, 16'd0, 1, 1'b1, 2));
		dir_rows.push_back(dir_row(CMD_POLL, 16'd0, 1, 1'b1, 2));
		// no end marker zero: failed poll at 42 clears the length
		dir_rows.push_back(dir_row(CMD_APPEND, 16'd1200, 40));
		dir_rows.push_back(dir_row(CMD_POLL, 16'd0, 1, 1'b1, 42));
		dir_rows.push_back(dir_row(CMD_POLL, 16'd0, 1, 1'b1, 0));
		// twelve-bit frame of all ones
		dir_rows.push_back(dir_row(CMD_APPEND, 16'd1200, 25));
		dir_rows.push_back(dir_row(CMD_APPEND, 16'd0, 1));
		dir_rows.push_back(dir_row(CMD_POLL, 16'd0, 1));
		// twenty-bit frame, durations on the exclusive bounds and just inside
		dir_rows.push_back(dir_row(CMD_APPEND, 16'd1100, 1));
		dir_rows.push_back(dir_row(CMD_APPEND, 16'd1300, 1));
		dir_rows.push_back(dir_row(CMD_APPEND, 16'd1100, 23));
		dir_rows.push_back(dir_row(CMD_APPEND, 16'd9, 1));
		dir_rows.push_back(dir_row(CMD_APPEND, 16'd1299, 15));
		dir_rows.push_back(dir_row(CMD_APPEND, 16'd0, 1));
		dir_rows.push_back(dir_row(CMD_POLL, 16'd0, 1));
		// both end markers zero: twelve-bit frame wins
		dir_rows.push_back(dir_row(CMD_APPEND, 16'd1101, 25));
		dir_rows.push_back(dir_row(CMD_APPEND, 16'd0, 1));
		dir_rows.push_back(dir_row(CMD_APPEND, 16'd1301, 15));
		dir_rows.push_back(dir_row(CMD_APPEND, 16'd0, 1));
		dir_rows.push_back(dir_row(CMD_POLL, 16'd0, 1));
		// length saturates at 255, poll duration is ignored
		dir_rows.push_back(dir_row(CMD_APPEND, 16'hFFFF, 300));
		dir_rows.push_back(dir_row(CMD_POLL, 16'hFFFF, 1, 1'b1, 255));
		dir_rows.push_back(dir_row(CMD_POLL, 16'd0, 1, 1'b1, 0));
		// all-zero frame after the saturation run: earlier bits must not leak through
		dir_rows.push_back(dir_row(CMD_APPEND, 16'd0, 26));
		dir_rows.push_back(dir_row(CMD_POLL, 16'd0, 1));

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			repeat (dir_rows[i].reps)
				send_req(dir_rows[i].cmd, dir_rows[i].dur, dir_rows[i].typed,
					dir_rows[i].want);
		drain_requests();

		// random phases, one bounds setting each, extremes included
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			src_idle_pct = 37;
			snk_idle_pct = 37;
			case (ph)
				0: begin
					lo = '0;
					hi = 16'hFFFF;
				end
				1: begin
					lo = 16'hFFFF;
					hi = '0;
				end
				2: begin
					lo = '0;
					hi = '0;
				end
				3: begin
					lo = 16'hFFFF;
					hi = 16'hFFFF;
				end
				4: begin
					// long stretch with no idling on either side
					lo = 16'($urandom_range(3000));
					hi = 16'(lo + $urandom_range(3000, 2));
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
				default: begin
					lo = ONE_BIT_MIN_RESET;
					hi = ONE_BIT_MAX_RESET;
				end
			endcase
			write_bounds(lo, hi);
			phase_start = req_count;
			while (req_count - phase_start < REQS_PER_PHASE) begin
				choice = $urandom_range(99);
				if (choice < 70) begin
					send_frame($urandom_range(1));
				end else if (choice < 98) begin
					send_noise();
				end else begin
					// run into length saturation
					repeat ($urandom_range(270, 250)) begin
						d = 16'($urandom);
						send_req(CMD_APPEND, d, 1'b0, '0);
					end
				end
			end
			drain_requests();
		end

		if (errors == 0 && pending_frames.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- sim.f -----
src/ipwd_pkg.sv
src/ipwd_core.sv
src/ir_pulse_width_frame_decoder.sv
bench/tb.sv
